// ===== hw/rtl/iil_pkg.sv =====
// ----------------------------------------------------------------------------
// iil_pkg - shared types and constants of the indexed insert/remove list
// Holds the list geometry, operation and status codes, and the structs that
// pass between the list controller and the entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package iil_pkg;

    localparam int DEPTH       = 64;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_GET    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_mode_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_mode_t             mode;
        logic [IDX_W-1:0]       idx;
        logic [ENTRY_WIDTH-1:0] wdata;
        logic                   rd_req;
    } cell_ctrl_t;

    // Read data travelling down the chain toward the last cell.
    typedef struct packed {
        logic                   vld;
        logic [ENTRY_WIDTH-1:0] data;
    } rd_link_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_insert_remove_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top - ordered list with insert/remove at index
// A row of entry cells shifts in parallel on insert and remove; a controller
// checks indexes, keeps the count and returns one response per request.
// ----------------------------------------------------------------------------
// Append, insert, remove, clear, spare and out-of-range requests answer in the cycle
// after acceptance, and a new request can be taken every cycle while responses are taken.
// A get walks the read data down the cell chain, through the register of each cell from
// the addressed one to the last; no new request is taken until the response is out.
// Reset clears the count and the handshake state; entry data is not reset.
`default_nettype none

module indexed_insert_remove_list_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // position[5:0], item_value[37:6], zero pad
    input  wire logic [2:0]  s_tuser,   // opcode[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // read_value[31:0], entry_count[38:32], zero pad
    output logic      [1:0]  m_tuser    // status[1:0]
);

    localparam int LAST = iil_pkg::DEPTH - 1;

    iil_pkg::state_t                    state_reg;
    iil_pkg::state_t                    state_next;
    logic [iil_pkg::CNT_W-1:0]          count_reg;
    logic [iil_pkg::CNT_W-1:0]          count_next;
    logic                               out_vld_reg;
    logic                               out_vld_next;
    logic [iil_pkg::VALUE_W-1:0]        out_value_reg;
    logic [iil_pkg::VALUE_W-1:0]        out_value_next;
    logic [iil_pkg::STATUS_W-1:0]       out_status_reg;
    logic [iil_pkg::STATUS_W-1:0]       out_status_next;
    logic [iil_pkg::COUNT_W-1:0]        out_count_reg;
    logic [iil_pkg::COUNT_W-1:0]        out_count_next;

    logic [iil_pkg::OPCODE_W-1:0]       opcode;
    logic [iil_pkg::POSITION_W-1:0]     position;
    logic [iil_pkg::VALUE_W-1:0]        item_value;
    logic                               s_acc;
    logic                               go_read;
    logic                               in_range;
    logic                               full;
    logic [iil_pkg::STATUS_W-1:0]       status;

    iil_pkg::cell_ctrl_t                ctrl;
    logic [iil_pkg::ENTRY_WIDTH-1:0]    entry_w [iil_pkg::DEPTH];
    iil_pkg::rd_link_t                  rd_w    [iil_pkg::DEPTH+1];

    assign opcode     = s_tuser;
    assign position   = s_tdata[5:0];
    assign item_value = s_tdata[37:6];

    assign s_tready = (state_reg == iil_pkg::S_IDLE) && (!out_vld_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign in_range = (iil_pkg::CNT_W'(position) < count_reg);
    assign full     = (count_reg >= iil_pkg::CNT_W'(iil_pkg::DEPTH));

    // Request decode: cell command, status and new count.
    always_comb
    begin
        ctrl.mode   = iil_pkg::CELL_HOLD;
        ctrl.idx    = iil_pkg::IDX_W'(position);
        ctrl.wdata  = iil_pkg::ENTRY_WIDTH'(item_value);
        ctrl.rd_req = 1'b0;
        status      = iil_pkg::ST_OK;
        count_next  = count_reg;
        go_read     = 1'b0;
        unique case (opcode)
            iil_pkg::OP_APPEND:
            begin
                ctrl.idx = count_reg[iil_pkg::IDX_W-1:0];
                if (full)
                    status = iil_pkg::ST_FULL;
                else
                begin
                    ctrl.mode  = iil_pkg::CELL_WRITE;
                    count_next = count_reg + 1'b1;
                end
            end
            iil_pkg::OP_INSERT:
            begin
                if (!in_range)
                    status = iil_pkg::ST_RANGE;
                else if (full)
                    status = iil_pkg::ST_FULL;
                else
                begin
                    ctrl.mode  = iil_pkg::CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            iil_pkg::OP_REMOVE:
            begin
                if (!in_range)
                    status = iil_pkg::ST_RANGE;
                else
                begin
                    ctrl.mode  = iil_pkg::CELL_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            iil_pkg::OP_GET:
            begin
                if (!in_range)
                    status = iil_pkg::ST_RANGE;
                else
                begin
                    ctrl.rd_req = 1'b1;
                    go_read     = 1'b1;
                end
            end
            iil_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = iil_pkg::ST_OK;
            end
        endcase
        if (!s_acc)
        begin
            ctrl.mode   = iil_pkg::CELL_HOLD;
            ctrl.rd_req = 1'b0;
            count_next  = count_reg;
            go_read     = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        unique case (state_reg)
            iil_pkg::S_IDLE:
            begin
                if (s_acc)
                begin
                    if (go_read)
                        state_next = iil_pkg::S_READ;
                    else
                    begin
                        out_vld_next    = 1'b1;
                        out_value_next  = '0;
                        out_status_next = status;
                        out_count_next  = iil_pkg::COUNT_W'(count_next);
                    end
                end
            end
            iil_pkg::S_READ:
            begin
                if (rd_w[iil_pkg::DEPTH].vld)
                begin
                    state_next      = iil_pkg::S_IDLE;
                    out_vld_next    = 1'b1;
                    out_value_next  = iil_pkg::VALUE_W'(rd_w[iil_pkg::DEPTH].data);
                    out_status_next = iil_pkg::ST_OK;
                    out_count_next  = iil_pkg::COUNT_W'(count_reg);
                end
            end
            default:
            begin
                state_next = iil_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iil_pkg::S_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rd_w[0] = '0;

    for (genvar k = 0; k < iil_pkg::DEPTH; k++)
    begin : g_cell
        logic [iil_pkg::ENTRY_WIDTH-1:0] left_entry;
        logic [iil_pkg::ENTRY_WIDTH-1:0] right_entry;

        if (k == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_mid_l
            assign left_entry = entry_w[k-1];
        end

        if (k == LAST)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid_r
            assign right_entry = entry_w[k+1];
        end

        iil_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cell_idx    (iil_pkg::IDX_W'(k)),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_w[k]),
            .rd_in       (rd_w[k]),
            .rd_out      (rd_w[k+1])
        );
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= iil_pkg::CNT_W'(iil_pkg::DEPTH))
        else $error("entry count above list depth");

    a_chain_only_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_w[iil_pkg::DEPTH].vld |-> state_reg == iil_pkg::S_READ)
        else $error("read data left the chain with no get pending");

    a_quick_response: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !go_read |=> m_tvalid)
        else $error("request without a response in the next cycle");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_acc |=> $stable(count_reg))
        else $error("entry count changed without a request");

endmodule

`default_nettype wire

// ===== hw/rtl/iil_cell.sv =====
// ----------------------------------------------------------------------------
// iil_cell - one entry of the list
// Holds one entry, takes a new value, its left or its right neighbor on
// write, insert and remove, and forwards read data one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iil_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire iil_pkg::cell_ctrl_t             ctrl,
    input  wire logic [iil_pkg::IDX_W-1:0]       cell_idx,
    input  wire logic [iil_pkg::ENTRY_WIDTH-1:0] left_entry,
    input  wire logic [iil_pkg::ENTRY_WIDTH-1:0] right_entry,
    output logic      [iil_pkg::ENTRY_WIDTH-1:0] entry,
    input  wire iil_pkg::rd_link_t               rd_in,
    output iil_pkg::rd_link_t                    rd_out
);

    logic [iil_pkg::ENTRY_WIDTH-1:0] entry_reg;
    logic [iil_pkg::ENTRY_WIDTH-1:0] entry_next;
    logic                            rd_vld_reg;
    logic [iil_pkg::ENTRY_WIDTH-1:0] rd_data_reg;
    iil_pkg::rd_link_t               rd_next;
    logic                            at_idx;
    logic                            above_idx;

    assign at_idx    = (cell_idx == ctrl.idx);
    assign above_idx = (cell_idx > ctrl.idx);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.mode)
            iil_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            iil_pkg::CELL_WRITE:
            begin
                if (at_idx)
                    entry_next = ctrl.wdata;
            end
            iil_pkg::CELL_INSERT:
            begin
                if (at_idx)
                    entry_next = ctrl.wdata;
                else if (above_idx)
                    entry_next = left_entry;
            end
            iil_pkg::CELL_REMOVE:
            begin
                if (at_idx || above_idx)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // On a read request the addressed cell launches its entry; otherwise each cell
    // passes on whatever arrives from the left.
    always_comb
    begin
        if (ctrl.rd_req && at_idx)
        begin
            rd_next.vld  = 1'b1;
            rd_next.data = entry_reg;
        end
        else
        begin
            rd_next = rd_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= rd_next.vld;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rd_next.data;
    end

    assign entry  = entry_reg;
    assign rd_out = {rd_vld_reg, rd_data_reg};

endmodule

`default_nettype wire

// ===== verif/indexed_insert_remove_list_top_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top_tb - self-checking bench for the indexed list
// Sends append, insert, remove, get and clear requests over the input stream
// and checks every response against a cycle-free model of the list. Directed
// corner cases run first, then random phases that fill, drain, mix and send noise. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list_top_tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 2;
    localparam int RANDOM_REQS    = 1300;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int POS_MAX        = (1 << iil_pkg::POSITION_W) - 1;
    localparam int DRAIN_CYCLES   = iil_pkg::DEPTH + 8;

    // Opcodes above clear are spare codes that the list ignores.
    localparam logic [iil_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = iil_pkg::OP_CLEAR + 3'd1;
    localparam logic [iil_pkg::OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [iil_pkg::OPCODE_W-1:0]   op;
        logic [iil_pkg::POSITION_W-1:0] pos;
        logic [iil_pkg::VALUE_W-1:0]    value;
    } list_req_t;

    typedef struct packed {
        logic [iil_pkg::VALUE_W-1:0]  read_value;
        logic [iil_pkg::STATUS_W-1:0] status;
        logic [iil_pkg::COUNT_W-1:0]  entry_count;
    } list_resp_t;

    typedef struct packed {
        logic [iil_pkg::DEPTH-1:0][iil_pkg::ENTRY_WIDTH-1:0] mem;
        logic [iil_pkg::COUNT_W-1:0]                         cnt;
    } list_image_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_NOISE
    } phase_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    list_req_t   pending_reqs[$];
    list_resp_t  expected_resps[$];
    list_image_t planned_list;
    list_image_t shadow_list;

    int cycles         = 0;
    int mismatches     = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_mode     = 0;
    int op_tally[8];
    int status_tally[4];
    int peak_count     = 0;
    int resp_seen      = 0;

    indexed_insert_remove_list_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // Applies one request to a list image and returns the response it gives.
    function automatic list_resp_t apply_list_op(inout list_image_t img,
                                                 input list_req_t rq);
        list_resp_t rsp;
        rsp        = '0;
        rsp.status = iil_pkg::ST_OK;
        case (rq.op)
            iil_pkg::OP_APPEND:
            begin
                if (img.cnt >= iil_pkg::DEPTH)
                    rsp.status = iil_pkg::ST_FULL;
                else
                begin
                    img.mem[img.cnt] = rq.value[iil_pkg::ENTRY_WIDTH-1:0];
                    img.cnt          = img.cnt + 1'b1;
                end
            end
            iil_pkg::OP_INSERT:
            begin
                if (rq.pos >= img.cnt)
                    rsp.status = iil_pkg::ST_RANGE;
                else if (img.cnt >= iil_pkg::DEPTH)
                    rsp.status = iil_pkg::ST_FULL;
                else
                begin
                    for (int k = iil_pkg::DEPTH - 1; k > 0; k--)
                        if (k > rq.pos && k <= img.cnt)
                            img.mem[k] = img.mem[k-1];
                    img.mem[rq.pos] = rq.value[iil_pkg::ENTRY_WIDTH-1:0];
                    img.cnt         = img.cnt + 1'b1;
                end
            end
            iil_pkg::OP_REMOVE:
            begin
                if (rq.pos >= img.cnt)
                    rsp.status = iil_pkg::ST_RANGE;
                else
                begin
                    for (int k = 0; k < iil_pkg::DEPTH - 1; k++)
                        if (k >= rq.pos && k + 1 < img.cnt)
                            img.mem[k] = img.mem[k+1];
                    img.cnt = img.cnt - 1'b1;
                end
            end
            iil_pkg::OP_GET:
            begin
                if (rq.pos >= img.cnt)
                    rsp.status = iil_pkg::ST_RANGE;
                else
                    rsp.read_value = iil_pkg::VALUE_W'(img.mem[rq.pos]);
            end
            iil_pkg::OP_CLEAR:
                img.cnt = '0;
            default: ;
        endcase
        rsp.entry_count = img.cnt;
        return rsp;
    endfunction

    task automatic queue_req(input logic [iil_pkg::OPCODE_W-1:0] op, input int pos,
                             input logic [iil_pkg::VALUE_W-1:0] value);
        list_req_t  rq;
        list_resp_t unused_rsp;
        rq.op      = op;
        rq.pos     = iil_pkg::POSITION_W'(pos);
        rq.value   = value;
        unused_rsp = apply_list_op(planned_list, rq);
        pending_reqs.push_back(rq);
    endtask

    // Mostly an index that is in range for the list as it will be.
    function automatic int pick_pos();
        if (planned_list.cnt == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, POS_MAX);
        return $urandom_range(0, planned_list.cnt - 1);
    endfunction

    function automatic logic [iil_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Sender: holds each request until taken, then idles in random gaps
    // between bursts of random length.
    always @(posedge clk or negedge rst_n)
    begin
        list_req_t rq;
        logic      holding;
        logic      next_valid;
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= '0;
            shadow_list = '0;
        end
        else
        begin
            holding    = s_tvalid;
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                rq = pending_reqs.pop_front();
                expected_resps.push_back(apply_list_op(shadow_list, rq));
                op_tally[rq.op]++;
                status_tally[expected_resps[$].status]++;
                if (shadow_list.cnt > peak_count)
                    peak_count = shadow_list.cnt;
                holding = 1'b0;
            end
            if (!holding)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() != 0)
                begin
                    rq         = pending_reqs[0];
                    next_valid = 1'b1;
                    s_tdata    <= {2'b00, rq.value, rq.pos};
                    s_tuser    <= rq.op;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 32);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 70)
                                                               : $urandom_range(0, 3);
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Receiver: drives ready from a stall pattern that is picked anew at random, timed by the cycle counter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (cycles % 256 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (cycles % 5 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        list_resp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            resp_seen++;
            if (expected_resps.size() == 0)
            begin
                $error("response with no request outstanding: tdata=%h tuser=%h",
                       m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_resps.pop_front();
                if (m_tdata[31:0] !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[38:32] !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_tdata[38:32]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int                           random_done;
        int                           phase_no;
        int                           phase_len;
        int                           roll;
        int                           pos;
        phase_t                       phase;
        logic [iil_pkg::OPCODE_W-1:0] op;
        logic                         timed_out;

        planned_list = '0;

        // Requests against an empty list, then the spare opcodes.
        queue_req(iil_pkg::OP_GET, 0, '0);
        queue_req(iil_pkg::OP_REMOVE, POS_MAX, '0);
        queue_req(iil_pkg::OP_INSERT, 0, 32'hDEAD_BEEF);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            queue_req(iil_pkg::OPCODE_W'(c), POS_MAX, '1);
        queue_req(iil_pkg::OP_APPEND, 0, '1);
        queue_req(iil_pkg::OP_APPEND, POS_MAX, '0);
        queue_req(iil_pkg::OP_INSERT, 0, 32'h8000_0001);
        queue_req(iil_pkg::OP_INSERT, 2, 32'h5A5A_A5A5);
        queue_req(iil_pkg::OP_GET, 0, '0);
        queue_req(iil_pkg::OP_GET, 3, '0);
        // An index equal to the count is already out of range.
        queue_req(iil_pkg::OP_GET, 4, '0);
        queue_req(iil_pkg::OP_INSERT, 4, 32'h0BAD_F00D);
        queue_req(iil_pkg::OP_REMOVE, 0, '0);
        queue_req(iil_pkg::OP_REMOVE, 2, '0);
        queue_req(iil_pkg::OP_REMOVE, POS_MAX, '0);
        queue_req(iil_pkg::OP_GET, 1, '0);
        // Clear keeps the old entry data, but a get must see only new appends.
        queue_req(iil_pkg::OP_CLEAR, 0, '0);
        queue_req(iil_pkg::OP_GET, 0, '0);
        queue_req(iil_pkg::OP_APPEND, 0, 32'h1234_5678);
        queue_req(iil_pkg::OP_GET, 0, '0);

        random_done = 0;
        phase_no    = 0;
        while (random_done < RANDOM_REQS)
        begin
            // Every fourth phase fills far enough to hit the full store.
            phase     = (phase_no % 4 == 0) ? PH_FILL : phase_t'($urandom_range(0, 3));
            phase_len = (phase == PH_FILL) ? 100 : $urandom_range(20, 120);
            for (int n = 0; n < phase_len && random_done < RANDOM_REQS; n++)
            begin
                roll = $urandom_range(0, 99);
                case (phase)
                    PH_FILL:
                        op = (roll < 60) ? iil_pkg::OP_APPEND :
                             (roll < 85) ? iil_pkg::OP_INSERT :
                             (roll < 95) ? iil_pkg::OP_GET : iil_pkg::OP_REMOVE;
                    PH_DRAIN:
                        op = (roll < 55) ? iil_pkg::OP_REMOVE :
                             (roll < 75) ? iil_pkg::OP_GET :
                             (roll < 90) ? iil_pkg::OP_INSERT : iil_pkg::OP_APPEND;
                    PH_MIXED:
                        op = (roll < 3) ? iil_pkg::OP_CLEAR :
                             iil_pkg::OP_APPEND + iil_pkg::OPCODE_W'(roll % 4);
                    default:
                        op = iil_pkg::OPCODE_W'($urandom_range(0, OP_SPARE_LAST));
                endcase
                pos = (phase == PH_NOISE) ? $urandom_range(0, POS_MAX) : pick_pos();
                queue_req(op, pos, pick_value());
                random_done++;
            end
            phase_no++;
        end

        while ((pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
               && cycles < CYCLE_LIMIT)
            @(posedge clk);
        timed_out = (cycles >= CYCLE_LIMIT);
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d appends, %0d inserts, %0d removes, %0d gets, %0d clears, %0d spare.",
                 op_tally[iil_pkg::OP_APPEND], op_tally[iil_pkg::OP_INSERT],
                 op_tally[iil_pkg::OP_REMOVE], op_tally[iil_pkg::OP_GET],
                 op_tally[iil_pkg::OP_CLEAR],
                 op_tally[5] + op_tally[6] + op_tally[7]);
        $display("Got %0d responses: %0d range errors, %0d full errors, list peaked at %0d.",
                 resp_seen, status_tally[iil_pkg::ST_RANGE],
                 status_tally[iil_pkg::ST_FULL], peak_count);
        if (!timed_out && mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
